@@ rtl/htssw_pkg.sv @@
// -----------------------------------------------------------------------------
// Half to single stream widener package
// Shared widths and the half to single precision conversion function.
// -----------------------------------------------------------------------------
package htssw_pkg;

    localparam int BEAT_WIDTH_DEF = 64;
    localparam int HALF_BITS      = 16;
    localparam int SINGLE_BITS    = 32;

    // Finds the leading one of a nonzero 10-bit subnormal fraction.
    function automatic logic [3:0] lead_one(input logic [9:0] man);
        logic [3:0] p;
        p = 4'd0;
        for (int i = 0; i < 10; i++)
        begin
            if (man[i])
            begin
                p = 4'(i);
            end
        end
        return p;
    endfunction

    function automatic logic [31:0] widen_half(input logic [15:0] h);
        logic [4:0]  ex;
        logic [9:0]  man;
        logic [3:0]  p;
        logic [9:0]  frac;
        logic [30:0] bits;
        ex   = h[14:10];
        man  = h[9:0];
        p    = lead_one(man);
        frac = 10'(man << (4'd10 - p));
        if (ex == 5'd0)
        begin
            if (man == 10'd0)
            begin
                bits = 31'd0;
            end
            else
            begin
                bits = {8'(p) + 8'd103, frac, 13'd0};
            end
        end
        else if (ex == 5'h1F)
        begin
            bits = {8'hFF, man, 13'd0};
        end
        else
        begin
            bits = {8'(ex) + 8'd112, man, 13'd0};
        end
        return {h[15], bits};
    endfunction

endpackage

@@ rtl/half_to_single_stream_widener.sv @@
// -----------------------------------------------------------------------------
// Half to single stream widener
// Splits each beat of packed half-precision values into beats of singles.
// -----------------------------------------------------------------------------
// Usage: the slave channel (s_axis_*) takes a beat of BEAT_WIDTH/16 halves with
// byte keep and last. The master channel (m_axis_*) gives, for each beat, a
// transaction with the lower half converted and, unless the beat is last with
// an empty upper keep, a second transaction with the upper half.
// tuser on the output carries item_done, set on the final transaction of a beat.
// Pipeline: three register stages (split, convert, output); split holds a beat,
// convert holds one selected half and output holds its converted singles.
// The single output port limits the rate: a full beat gives two transactions,
// a short final beat one; a new beat is taken as the held one issues its last.
// Reset clears all valid bits; no transaction is in flight afterwards.
// When the receiver stalls, every full stage holds its contents while empty
// stages fill, then the splitter stops taking beats; nothing is lost or repeated.
// -----------------------------------------------------------------------------
module half_to_single_stream_widener #(
    parameter int BEAT_WIDTH = htssw_pkg::BEAT_WIDTH_DEF
) (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    s_axis_tvalid,
    output logic                    s_axis_tready,
    input  logic [BEAT_WIDTH-1:0]   s_axis_tdata,   // beat_data
    input  logic [BEAT_WIDTH/8-1:0] s_axis_tkeep,   // beat_keep
    input  logic                    s_axis_tlast,   // beat_last
    output logic                    m_axis_tvalid,
    input  logic                    m_axis_tready,
    output logic [BEAT_WIDTH-1:0]   m_axis_tdata,   // out_data
    output logic [BEAT_WIDTH/8-1:0] m_axis_tkeep,   // out_keep
    output logic                    m_axis_tlast,   // out_last
    output logic                    m_axis_tuser    // item_done
);

    localparam int HW   = BEAT_WIDTH / 2;
    localparam int KW   = BEAT_WIDTH / 16;
    localparam int NH   = HW / htssw_pkg::HALF_BITS;

    // Stage 0: holds an accepted beat and feeds out its halves.
    logic                    s0_valid_reg;
    logic                    s0_upper_reg;
    logic [BEAT_WIDTH-1:0]   s0_data_reg;
    logic [BEAT_WIDTH/8-1:0] s0_keep_reg;
    logic                    s0_last_reg;
    // Stage 1: one half selected.
    logic                    s1_valid_reg;
    logic [HW-1:0]           s1_data_reg;
    logic [KW-1:0]           s1_keep_reg;
    logic                    s1_last_reg;
    logic                    s1_done_reg;
    // Stage 2: output register.
    logic                    s2_valid_reg;
    logic [BEAT_WIDTH-1:0]   s2_data_reg;
    logic [BEAT_WIDTH/8-1:0] s2_keep_reg;
    logic                    s2_last_reg;
    logic                    s2_done_reg;

    logic adv2, adv1, adv0, short_beat, s0_done;
    logic [BEAT_WIDTH-1:0]   conv_data;
    logic [BEAT_WIDTH/8-1:0] conv_keep;

    assign adv2 = !s2_valid_reg || m_axis_tready;
    assign adv1 = !s1_valid_reg || adv2;
    assign short_beat = s0_last_reg && (s0_keep_reg[BEAT_WIDTH/8-1:BEAT_WIDTH/16] == '0);
    assign s0_done = s0_upper_reg || short_beat;
    assign adv0 = s0_valid_reg && adv1;
    assign s_axis_tready = !s0_valid_reg || (adv1 && s0_done);

    always_comb
    begin
        for (int j = 0; j < NH; j++)
        begin
            conv_data[j*32 +: 32] = htssw_pkg::widen_half(s1_data_reg[j*16 +: 16]);
            conv_keep[j*4 +: 4]   = (s1_keep_reg[j*2 +: 2] == 2'b11) ? 4'hF : 4'h0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg <= 1'b0;
            s0_upper_reg <= 1'b0;
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                s0_valid_reg <= 1'b1;
                s0_upper_reg <= 1'b0;
            end
            else if (adv0)
            begin
                if (s0_done)
                begin
                    s0_valid_reg <= 1'b0;
                end
                s0_upper_reg <= 1'b1;
            end
            if (adv1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (adv2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            s0_data_reg <= s_axis_tdata;
            s0_keep_reg <= s_axis_tkeep;
            s0_last_reg <= s_axis_tlast;
        end
        if (adv0)
        begin
            s1_data_reg <= s0_upper_reg ? s0_data_reg[BEAT_WIDTH-1:HW] : s0_data_reg[HW-1:0];
            s1_keep_reg <= s0_upper_reg ? s0_keep_reg[BEAT_WIDTH/8-1:BEAT_WIDTH/16]
                                        : s0_keep_reg[BEAT_WIDTH/16-1:0];
            s1_last_reg <= s0_last_reg && s0_done;
            s1_done_reg <= s0_done;
        end
        if (adv2 && s1_valid_reg)
        begin
            s2_data_reg <= conv_data;
            s2_keep_reg <= conv_keep;
            s2_last_reg <= s1_last_reg;
            s2_done_reg <= s1_done_reg;
        end
    end

    assign m_axis_tvalid = s2_valid_reg;
    assign m_axis_tdata  = s2_data_reg;
    assign m_axis_tkeep  = s2_keep_reg;
    assign m_axis_tlast  = s2_last_reg;
    assign m_axis_tuser  = s2_done_reg;

    // A last transaction always closes its beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |-> m_axis_tuser)
        else $error("out_last without item_done");

    // A stalled output transaction stays valid and holds its data.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("output changed under stall");

    // A new beat is never taken while the held one still owes its upper half.
    assert property (@(posedge clk) disable iff (!rst_n)
        s0_valid_reg && !s0_done |-> !s_axis_tready)
        else $error("beat accepted before upper half issued");

endmodule
